[rtl/swl_pkg.sv]
package swl_pkg;

    localparam int LAP_SLOTS = 16;

    localparam int REQ_W   = 3;
    localparam int IDX_W   = 4;
    localparam int TIME_W  = 32;
    localparam int LAPS_W  = 5;
    localparam int PTR_W   = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
    localparam int CNT_W   = $clog2(LAP_SLOTS + 1);
    localparam int SUM_W   = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
    localparam int ENTRY_W = 2 * TIME_W;

    localparam int IN_W  = 8;
    localparam int OUT_W = 104;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 3'd0,
        REQ_START  = 3'd1,
        REQ_PAUSE  = 3'd2,
        REQ_RESUME = 3'd3,
        REQ_RESET  = 3'd4,
        REQ_LAP    = 3'd5,
        REQ_READ   = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    typedef struct packed {
        logic exec;     // apply the accepted request
        logic load_rd;  // load the result from the lap store read
    } t_dp_cmd;

    typedef struct packed {
        logic req_is_read;
    } t_dp_sts;

endpackage

[rtl/swl_ctrl.sv]
module swl_ctrl
    import swl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    s_axis_tvalid,
    output logic    s_axis_tready,
    output logic    m_axis_tvalid,
    input  logic    m_axis_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !m_axis_tready;
        o_cmd.exec   = 1'b0;
        o_cmd.load_rd = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.exec = 1'b1;
                    if (i_sts.req_is_read) begin
                        n_state = ST_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_READ: begin
                // store data is registered now; output slot is empty here
                o_cmd.load_rd = 1'b1;
                n_out_valid   = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/swl_dp.sv]
module swl_dp
    import swl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IN_W-1:0]  i_tdata,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output logic [OUT_W-1:0] o_tdata
);

    t_req              w_req;
    logic [IDX_W-1:0]  w_idx;

    logic              r_run, n_run;
    logic              r_pause, n_pause;
    logic [TIME_W-1:0] r_elapsed, n_elapsed;
    logic [TIME_W-1:0] r_prev, n_prev;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  r_head, n_head;

    logic               w_wr_en;
    logic [PTR_W-1:0]   w_wr_addr;
    logic [TIME_W-1:0]  w_split;
    logic [SUM_W-1:0]   w_tail_sum, w_tail_wrap;
    logic [SUM_W-1:0]   w_rd_sum, w_rd_wrap;
    logic [PTR_W-1:0]   w_head_inc;
    logic               w_full;
    logic               w_rd_ok;

    logic [ENTRY_W-1:0] r_mem [LAP_SLOTS];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               r_rd_ok;

    logic [TIME_W-1:0]  r_o_elapsed;
    logic               r_o_run;
    logic               r_o_pause;
    logic [LAPS_W-1:0]  r_o_laps;
    logic [TIME_W-1:0]  r_o_total;
    logic [TIME_W-1:0]  r_o_split;

    logic [CNT_W+LAPS_W-1:0] w_laps_ext;
    logic [CNT_W+LAPS_W-1:0] w_laps_cur;

    assign w_req = t_req'(i_tdata[REQ_W-1:0]);
    assign w_idx = i_tdata[REQ_W+IDX_W-1:REQ_W];
    assign o_sts.req_is_read = (w_req == REQ_READ);

    assign w_full     = (r_count == CNT_W'(LAP_SLOTS));
    assign w_head_inc = (r_head == PTR_W'(LAP_SLOTS - 1)) ? '0 : r_head + 1'b1;
    assign w_split    = r_elapsed - r_prev;

    // ring positions: sums stay below twice the slot count where they matter
    assign w_tail_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_tail_wrap = (w_tail_sum >= SUM_W'(LAP_SLOTS)) ?
                         w_tail_sum - SUM_W'(LAP_SLOTS) : w_tail_sum;
    assign w_rd_sum    = SUM_W'(r_head) + SUM_W'(w_idx);
    assign w_rd_wrap   = (w_rd_sum >= SUM_W'(LAP_SLOTS)) ?
                         w_rd_sum - SUM_W'(LAP_SLOTS) : w_rd_sum;
    assign w_rd_ok     = (SUM_W'(w_idx) < SUM_W'(r_count));

    always_comb begin
        n_run     = r_run;
        n_pause   = r_pause;
        n_elapsed = r_elapsed;
        n_prev    = r_prev;
        n_count   = r_count;
        n_head    = r_head;
        w_wr_en   = 1'b0;
        w_wr_addr = w_tail_wrap[PTR_W-1:0];
        case (w_req)
            REQ_TICK: begin
                if (r_run && !r_pause) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end
            REQ_START, REQ_RESET: begin
                n_run     = (w_req == REQ_START);
                n_pause   = 1'b0;
                n_elapsed = '0;
                n_prev    = '0;
                n_count   = '0;
                n_head    = '0;
            end
            REQ_PAUSE: begin
                if (r_run && !r_pause) begin
                    n_pause = 1'b1;
                end
            end
            REQ_RESUME: begin
                if (r_run && r_pause) begin
                    n_pause = 1'b0;
                end
            end
            REQ_LAP: begin
                if (r_run) begin
                    w_wr_en = 1'b1;
                    n_prev  = r_elapsed;
                    if (w_full) begin
                        // overwrite the oldest slot and advance past it
                        w_wr_addr = r_head;
                        n_head    = w_head_inc;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign w_laps_ext = {{LAPS_W{1'b0}}, n_count};
    assign w_laps_cur = {{LAPS_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_pause   <= 1'b0;
            r_elapsed <= '0;
            r_prev    <= '0;
            r_count   <= '0;
            r_head    <= '0;
        end else if (i_cmd.exec) begin
            r_run     <= n_run;
            r_pause   <= n_pause;
            r_elapsed <= n_elapsed;
            r_prev    <= n_prev;
            r_count   <= n_count;
            r_head    <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr_en) begin
            r_mem[w_wr_addr] <= {w_split, r_elapsed};
        end
        if (i_cmd.exec && o_sts.req_is_read) begin
            r_rd_data <= r_mem[w_rd_wrap[PTR_W-1:0]];
            r_rd_ok   <= w_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !o_sts.req_is_read) begin
            r_o_elapsed <= n_run ? n_elapsed : '0;
            r_o_run     <= n_run;
            r_o_pause   <= n_pause;
            r_o_laps    <= w_laps_ext[LAPS_W-1:0];
            r_o_total   <= '0;
            r_o_split   <= '0;
        end else if (i_cmd.load_rd) begin
            r_o_elapsed <= r_run ? r_elapsed : '0;
            r_o_run     <= r_run;
            r_o_pause   <= r_pause;
            r_o_laps    <= w_laps_cur[LAPS_W-1:0];
            r_o_total   <= r_rd_ok ? r_rd_data[TIME_W-1:0] : '0;
            r_o_split   <= r_rd_ok ? r_rd_data[ENTRY_W-1:TIME_W] : '0;
        end
    end

    assign o_tdata = {1'b0, r_o_split, r_o_total, r_o_laps, r_o_pause, r_o_run, r_o_elapsed};

endmodule

[rtl/stopwatch_with_lap_log_unit.sv]
// Millisecond stopwatch with a ring log of the most recent laps.
// Input stream (s_axis): one beat per request: tick, start, pause, resume,
// reset, lap or lap read. Output stream (m_axis): one result beat per
// request, showing the watch state after that request.
// The result of an accepted beat is valid in the cycle after it for all requests
// but lap read, which passes first through the registered lap store read port.
// Throughput: one request per cycle if the receiver keeps up; none while a
// lap read waits on the lap store: one write port, one registered read port.
// The log is a ring in the store: a lap when full overwrites the oldest
// slot, so no entry moves.
// Reset (i_rst_n low at a clock edge) stops the watch, zeroes the count
// and empties the log; the store contents are not cleared.
// A stalled receiver holds the result beat; a new request is taken in the
// cycle that result is drained, and none while it waits.
module stopwatch_with_lap_log_unit
    import swl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] req_type, [6:3] lap_index, [7] zero
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [31:0] elapsed_ms, [32] is_running, [33] is_paused, [38:34] laps_stored,
    // [70:39] lap_total_ms, [102:71] lap_split_ms, [103] zero
    output logic [OUT_W-1:0] m_axis_tdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    swl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    swl_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tdata (s_axis_tdata),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_tdata (m_axis_tdata)
    );

endmodule
